@@ hdl/cis_pkg.sv @@
// ----------------------------------------------------------------------------
// cis_pkg
// Shared types, sizes and helpers for the case-insensitive substring search.
// ----------------------------------------------------------------------------
package cis_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int COUNT_BITS  = 16;
  localparam int STORE_BYTES = 16;
  localparam int LEN_LIMIT   = (PATTERN_MAX < STORE_BYTES) ? PATTERN_MAX : STORE_BYTES;

  localparam int LEN_BITS    = 5;
  localparam int ADDR_BITS   = 5;
  localparam int DATA_BITS   = 64;
  localparam int START_BITS  = 16;

  localparam logic [7:0] CASE_OFFSET = 8'd32;

  // register index, taken from paddr[4:3]
  localparam logic [1:0] REG_PAT_LOW  = 2'd0;
  localparam logic [1:0] REG_PAT_HIGH = 2'd1;
  localparam logic [1:0] REG_PAT_LEN  = 2'd2;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_beat_t;

  typedef struct packed {
    logic                  hit_now;
    logic [START_BITS-1:0] hit_start;
    logic                  no_hit;
    logic                  last;
  } out_beat_t;

  typedef struct packed {
    logic [DATA_BITS-1:0] bytes_low;
    logic [DATA_BITS-1:0] bytes_high;
    logic [LEN_BITS-1:0]  length;
  } pattern_t;

  typedef struct packed {
    logic advance;
    logic clear;
  } cell_ctrl_t;

  // map A-Z onto a-z, leave every other byte alone
  function automatic logic [7:0] fold_case(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r = b + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

@@ hdl/case_insensitive_substring_search_unit.sv @@
// ----------------------------------------------------------------------------
// case_insensitive_substring_search_unit
// Shift-and substring search over a byte stream, letters folded to lower case.
// ----------------------------------------------------------------------------
// Usage:
//   Load the pattern through the cfg_ port (pattern bytes 0-7 at 0x00, bytes
//   8-15 at 0x08, length at 0x10) while the stream is idle. Then send text
//   one byte per in_ beat, with end_of_text on the last byte of each string.
//   Every input beat gives exactly one out_ beat: hit_now with hit_start on
//   the byte that completes the first occurrence, no_hit on the last byte
//   of a string without one, and last echoing end_of_text.
// Timing:
//   One row of cells, one per pattern position, updates all prefix bits
//   in the same cycle, so a byte is taken every clock unless out_stall holds
//   a result. The output register shows each result the cycle after its byte.
// Stall:
//   A held result stalls the input only while out_stall is high; otherwise a
//   new byte enters as the previous result leaves.
// Reset:
//   Synchronous reset clears the prefix bits, the byte count, the hit latch
//   and the output valid flag, and loads pattern zero with length one.
// ----------------------------------------------------------------------------
module case_insensitive_substring_search_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  cis_pkg::in_beat_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output cis_pkg::out_beat_t             out_data,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [cis_pkg::ADDR_BITS-1:0]  cfg_paddr,
  input  logic [cis_pkg::DATA_BITS-1:0]  cfg_pwdata,
  output logic [cis_pkg::DATA_BITS-1:0]  cfg_prdata,
  output logic                           cfg_pready
);
  import cis_pkg::*;

  pattern_t              pattern;
  cell_ctrl_t            ctrl;
  logic                  accept;
  logic [7:0]            text_folded;
  logic [LEN_BITS-1:0]   len_used;
  logic [PATTERN_MAX-1:0] prefix_cur;
  logic [PATTERN_MAX-1:0] prefix_nxt;
  logic [PATTERN_MAX-1:0] tap_sel;
  logic                  tap_hit;
  logic                  hit;
  logic [COUNT_BITS-1:0] start_pos;

  logic [COUNT_BITS-1:0] count_r;
  logic                  found_r;
  logic                  out_valid_r;
  out_beat_t             out_data_r;

  cis_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .pattern     (pattern)
  );

  assign in_stall    = out_valid_r & out_stall;
  assign accept      = in_valid & ~in_stall;
  assign text_folded = fold_case(in_data.text_byte);
  assign ctrl.advance = accept;
  assign ctrl.clear   = in_data.end_of_text;

  // clamp length to 1..LEN_LIMIT
  always_comb begin
    len_used = pattern.length;
    if (pattern.length == '0) begin
      len_used = LEN_BITS'(1);
    end else if (pattern.length > LEN_BITS'(LEN_LIMIT)) begin
      len_used = LEN_BITS'(LEN_LIMIT);
    end
  end

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    logic       en;
    logic [7:0] pbyte;
    logic       prev;

    if (i < LEN_LIMIT) begin : g_used
      assign en = (LEN_BITS'(i) < len_used);
      if (i < 8) begin : g_low
        assign pbyte = pattern.bytes_low[8*i +: 8];
      end else begin : g_high
        assign pbyte = pattern.bytes_high[8*(i-8) +: 8];
      end
    end else begin : g_spare
      assign en    = 1'b0;
      assign pbyte = 8'h00;
    end

    if (i == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_link
      assign prev = prefix_cur[i-1];
    end

    assign tap_sel[i] = (i < LEN_LIMIT) && (len_used == LEN_BITS'(i + 1));

    cis_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctrl         (ctrl),
      .enable       (en),
      .text_folded  (text_folded),
      .pattern_byte (pbyte),
      .prefix_in    (prev),
      .prefix_nxt   (prefix_nxt[i]),
      .prefix_out   (prefix_cur[i])
    );
  end

  assign tap_hit   = |(prefix_nxt & tap_sel);
  assign hit       = tap_hit & ~found_r;
  assign start_pos = count_r - COUNT_BITS'(len_used - LEN_BITS'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        out_valid_r <= 1'b1;
        if (in_data.end_of_text) begin
          count_r <= '0;
          found_r <= 1'b0;
        end else begin
          if (count_r != '1) begin
            count_r <= count_r + COUNT_BITS'(1);
          end
          if (hit) begin
            found_r <= 1'b1;
          end
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r.hit_now   <= hit;
      out_data_r.hit_start <= hit ? START_BITS'(start_pos) : '0;
      out_data_r.no_hit    <= in_data.end_of_text & ~(found_r | hit);
      out_data_r.last      <= in_data.end_of_text;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hdl/cis_cell.sv @@
// ----------------------------------------------------------------------------
// cis_cell
// One pattern position: holds its prefix-match bit and extends the match
// handed over by the previous position when its byte equals the text byte.
// ----------------------------------------------------------------------------
module cis_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  cis_pkg::cell_ctrl_t ctrl,
  input  logic                enable,
  input  logic [7:0]          text_folded,
  input  logic [7:0]          pattern_byte,
  input  logic                prefix_in,
  output logic                prefix_nxt,
  output logic                prefix_out
);
  import cis_pkg::*;

  logic prefix_r;

  assign prefix_nxt = enable & prefix_in & (fold_case(pattern_byte) == text_folded);
  assign prefix_out = prefix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r <= 1'b0;
    end else if (ctrl.advance) begin
      prefix_r <= ctrl.clear ? 1'b0 : prefix_nxt;
    end
  end

endmodule

@@ hdl/cis_cfg.sv @@
// ----------------------------------------------------------------------------
// cis_cfg
// Register file for the pattern bytes and the pattern length.
// ----------------------------------------------------------------------------
module cis_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [cis_pkg::ADDR_BITS-1:0]  cfg_paddr,
  input  logic [cis_pkg::DATA_BITS-1:0]  cfg_pwdata,
  output logic [cis_pkg::DATA_BITS-1:0]  cfg_prdata,
  output logic                           cfg_pready,
  output cis_pkg::pattern_t              pattern
);
  import cis_pkg::*;

  logic [DATA_BITS-1:0] low_r;
  logic [DATA_BITS-1:0] high_r;
  logic [LEN_BITS-1:0]  len_r;
  logic                 wr_en;
  logic [1:0]           reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign reg_idx    = cfg_paddr[4:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= '0;
      high_r <= '0;
      len_r  <= LEN_BITS'(1);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PAT_LOW:  low_r  <= cfg_pwdata;
        REG_PAT_HIGH: high_r <= cfg_pwdata;
        REG_PAT_LEN:  len_r  <= cfg_pwdata[LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PAT_LOW:  cfg_prdata = low_r;
      REG_PAT_HIGH: cfg_prdata = high_r;
      REG_PAT_LEN:  cfg_prdata = DATA_BITS'(len_r);
      default:      cfg_prdata = '0;
    endcase
  end

  assign pattern.bytes_low  = low_r;
  assign pattern.bytes_high = high_r;
  assign pattern.length     = len_r;

endmodule
